// ===== hdl/sfh_pkg.sv =====
// ----------------------------------------------------------------------------
// sfh_pkg
// Shared types, constants and size-class function of the segregated-fit heap.
// ----------------------------------------------------------------------------
package sfh_pkg;

	localparam int HEAP_BITS_DEF   = 16;
	localparam int ALIGN_BYTES_DEF = 8;

	localparam logic [31:0] F_EMPTY      = 32'h0000_0001;
	localparam logic [31:0] F_PREV_EMPTY = 32'h0000_0002;
	localparam logic [31:0] SIZE_FIELD   = 32'hFFFF_FFFC;
	localparam logic [31:0] USED_HDR     = 32'd8;
	localparam logic [31:0] FREE_HDR     = 32'd16;

	localparam logic [1:0] W_PSIZE = 2'd0;
	localparam logic [1:0] W_SIZE  = 2'd1;
	localparam logic [1:0] W_NEXT  = 2'd2;
	localparam logic [1:0] W_PREV  = 2'd3;

	// one access of the word/bin store
	typedef struct packed {
		logic        rd;
		logic        wr;
		logic [31:0] node;
		logic [1:0]  w;
		logic [31:0] wdata;
	} sfh_mreq_t;

	function automatic logic [31:0] class_of(input logic [31:0] s, input int hb);
		logic [31:0] r;
		logic [31:0] nb;
		int          b;
		b = hb;
		for (int n = 31; n >= 1; n--) begin
			if (n < hb && ((32'(1) << n) - 32'd1) >= s) begin
				b = n;
			end
		end
		if (s <= 32'd32) begin
			r = s >> 2;
		end else begin
			r = 32'((b - 4) * 4) + ((s >> (b - 3)) & 32'h3);
		end
		nb = 32'((hb - 3) * 4);
		if (r >= nb) begin
			r = nb - 32'd1;
		end
		return r;
	endfunction

endpackage

// ===== hdl/sfh_if.sv =====
// ----------------------------------------------------------------------------
// sfh_if
// Request and response channels of the heap allocator.
// ----------------------------------------------------------------------------
interface sfh_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [15:0] req_size;
	logic [15:0] free_offset;
	modport source (output valid, output req_type, output req_size, output free_offset,
		input ready);
	modport sink (input valid, input req_type, input req_size, input free_offset,
		output ready);
endinterface

interface sfh_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] user_offset;
	logic        status;
	modport source (output valid, output user_offset, output status, input ready);
	modport sink (input valid, input user_offset, input status, output ready);
endinterface

// ===== hdl/segregated_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// segregated_fit_heap_allocator
// Segregated free-list allocator with boundary tags, run by a sequencer over
// one single-port word/bin store.
// ----------------------------------------------------------------------------
// The time from accept to response valid depends on the kind of request (null
// free, free, allocate without space, whole-block allocate or split) and, for
// an allocate, on the number of bins read.
// A new request is taken only in the idle state, once the last one is done; an
// unread response holds the sequencer in its last state until that beat is taken.
// Reset: a clearing pass of the store, then the sequencer builds the free block.
module segregated_fit_heap_allocator #(
	parameter int HEAP_BITS   = sfh_pkg::HEAP_BITS_DEF,
	parameter int ALIGN_BYTES = sfh_pkg::ALIGN_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sfh_req_if.sink   req,
	sfh_rsp_if.source rsp
);
	localparam int NBINS = (HEAP_BITS - 3) * 4;
	localparam int BW    = $clog2(NBINS + 1);
	localparam logic [31:0] HEAP_SIZE  = 32'(1) << HEAP_BITS;
	localparam logic [31:0] HEAP_MASK  = HEAP_SIZE - 32'd1;
	localparam int          BODY_INT   = (ALIGN_BYTES - (8 % ALIGN_BYTES)) % ALIGN_BYTES;
	localparam logic [31:0] BODY_START = 32'(BODY_INT);
	localparam logic [31:0] BSIZE      = HEAP_SIZE - BODY_START - 32'd8;
	localparam logic [31:0] ALIGN_MASK = ~(32'(ALIGN_BYTES) - 32'd1);

	localparam logic [5:0] S_CLR   = 6'd0;
	localparam logic [5:0] S_INIT  = 6'd1;
	localparam logic [5:0] S_INIT2 = 6'd2;
	localparam logic [5:0] S_IDLE  = 6'd3;
	localparam logic [5:0] S_A0    = 6'd4;
	localparam logic [5:0] S_A1    = 6'd5;
	localparam logic [5:0] S_A2    = 6'd6;
	localparam logic [5:0] S_A3    = 6'd7;
	localparam logic [5:0] S_A4    = 6'd8;
	localparam logic [5:0] S_A5    = 6'd9;
	localparam logic [5:0] S_A6    = 6'd10;
	localparam logic [5:0] S_A7    = 6'd11;
	localparam logic [5:0] S_A8    = 6'd12;
	localparam logic [5:0] S_W0    = 6'd13;
	localparam logic [5:0] S_W1    = 6'd14;
	localparam logic [5:0] S_F0    = 6'd15;
	localparam logic [5:0] S_F1    = 6'd16;
	localparam logic [5:0] S_F2    = 6'd17;
	localparam logic [5:0] S_F3    = 6'd18;
	localparam logic [5:0] S_F4    = 6'd19;
	localparam logic [5:0] S_F5    = 6'd20;
	localparam logic [5:0] S_F6    = 6'd21;
	localparam logic [5:0] S_F7    = 6'd22;
	localparam logic [5:0] S_F8    = 6'd23;
	localparam logic [5:0] S_B0    = 6'd24;
	localparam logic [5:0] S_B1    = 6'd25;
	localparam logic [5:0] S_B2    = 6'd26;
	localparam logic [5:0] S_B3    = 6'd27;
	localparam logic [5:0] S_C0    = 6'd28;
	localparam logic [5:0] S_C1    = 6'd29;
	localparam logic [5:0] S_C2    = 6'd30;
	localparam logic [5:0] S_U0    = 6'd31;
	localparam logic [5:0] S_U1    = 6'd32;
	localparam logic [5:0] S_U2    = 6'd33;
	localparam logic [5:0] S_U3    = 6'd34;
	localparam logic [5:0] S_U4    = 6'd35;
	localparam logic [5:0] S_L0    = 6'd36;
	localparam logic [5:0] S_L1    = 6'd37;
	localparam logic [5:0] S_L2    = 6'd38;
	localparam logic [5:0] S_L3    = 6'd39;
	localparam logic [5:0] S_L4    = 6'd40;
	localparam logic [5:0] S_L5    = 6'd41;
	localparam logic [5:0] S_P0    = 6'd42;
	localparam logic [5:0] S_P1    = 6'd43;
	localparam logic [5:0] S_P2    = 6'd44;
	localparam logic [5:0] S_DONE  = 6'd45;

	logic [5:0]           state_q;
	logic [5:0]           ret_q;
	logic [15:0]          rsize_q;
	logic [BW-1:0]        bin_q;
	logic [HEAP_BITS-1:0] addr_q;
	logic [HEAP_BITS-1:0] nxt_q;
	logic [HEAP_BITS-1:0] prev_q;
	logic [HEAP_BITS-1:0] sa_q;
	logic [31:0]          sv_q;
	logic [31:0]          sw_q;
	logic [31:0]          size_q;
	logic [31:0]          nsize_q;
	logic                 nempty_q;
	logic [31:0]          psize_q;
	logic [31:0]          user_q;
	logic [31:0]          newb_q;
	logic                 split_q;
	logic [31:0]          t1_q;
	logic [31:0]          t2_q;
	logic                 status_q;
	logic                 out_vld_q;
	logic [15:0]          out_user_q;
	logic                 out_stat_q;

	sfh_pkg::sfh_mreq_t mreq;
	logic [31:0]        mrd;
	logic               mem_ready;

	logic [31:0]          csz;
	logic [HEAP_BITS-1:0] nxt_w;
	logic [31:0]          user_w;
	logic [31:0]          newb_w;
	logic [31:0]          bin_node;
	logic [31:0]          lbin_node;

	sfh_store #(.HEAP_BITS(HEAP_BITS)) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.mreq   (mreq),
		.rdata  (mrd),
		.ready  (mem_ready)
	);

	assign csz       = mrd & sfh_pkg::SIZE_FIELD;
	assign nxt_w     = addr_q + csz[HEAP_BITS-1:0];
	assign user_w    = (32'(nxt_w) + 32'd4 - 32'(rsize_q)) & ALIGN_MASK;
	assign newb_w    = user_w - sfh_pkg::USED_HDR;
	assign bin_node  = HEAP_SIZE + 32'(bin_q);
	assign lbin_node = HEAP_SIZE + sfh_pkg::class_of(sv_q - 32'd4, HEAP_BITS);

	always_comb begin
		mreq = '0;
		case (state_q)
			S_INIT2: begin
				mreq.wr = 1'b1; mreq.node = BODY_START; mreq.w = sfh_pkg::W_SIZE;
				mreq.wdata = BSIZE | sfh_pkg::F_EMPTY;
			end
			S_A1: begin
				mreq.rd = 1'b1; mreq.node = bin_node; mreq.w = sfh_pkg::W_NEXT;
			end
			S_A3, S_W0: begin
				mreq.rd = 1'b1; mreq.node = 32'(addr_q); mreq.w = sfh_pkg::W_SIZE;
			end
			S_A5: begin
				mreq.wr = split_q; mreq.node = 32'(addr_q); mreq.w = sfh_pkg::W_SIZE;
				mreq.wdata = (newb_q - 32'(addr_q)) | sfh_pkg::F_EMPTY;
			end
			S_A6: begin
				mreq.wr = 1'b1; mreq.node = newb_q; mreq.w = sfh_pkg::W_SIZE;
				mreq.wdata = 32'(nxt_q) - newb_q;
			end
			S_A7, S_F2: begin
				mreq.rd = 1'b1; mreq.node = 32'(nxt_q); mreq.w = sfh_pkg::W_SIZE;
			end
			S_A8: begin
				mreq.wr = 1'b1; mreq.node = 32'(nxt_q); mreq.w = sfh_pkg::W_SIZE;
				mreq.wdata = mrd & ~sfh_pkg::F_PREV_EMPTY;
			end
			S_W1: begin
				mreq.wr = 1'b1; mreq.node = 32'(addr_q); mreq.w = sfh_pkg::W_SIZE;
				mreq.wdata = mrd & ~sfh_pkg::F_EMPTY;
			end
			S_F0, S_C1: begin
				mreq.rd = 1'b1; mreq.node = 32'(addr_q); mreq.w = sfh_pkg::W_SIZE;
			end
			S_F3: begin
				mreq.rd = sw_q[1]; mreq.node = 32'(addr_q); mreq.w = sfh_pkg::W_PSIZE;
			end
			S_F7: begin
				mreq.wr = 1'b1; mreq.node = 32'(prev_q); mreq.w = sfh_pkg::W_SIZE;
				mreq.wdata = psize_q | sfh_pkg::F_EMPTY;
			end
			S_B2: begin
				mreq.wr = 1'b1; mreq.node = 32'(addr_q); mreq.w = sfh_pkg::W_SIZE;
				mreq.wdata = size_q | sfh_pkg::F_EMPTY;
			end
			S_B3: begin
				mreq.wr = 1'b1; mreq.node = 32'(addr_q + size_q[HEAP_BITS-1:0]);
				mreq.w = sfh_pkg::W_PSIZE; mreq.wdata = size_q;
			end
			S_C2: begin
				mreq.wr = 1'b1; mreq.node = 32'(addr_q); mreq.w = sfh_pkg::W_SIZE;
				mreq.wdata = mrd | sfh_pkg::F_EMPTY;
			end
			S_U0, S_P0: begin
				mreq.rd = 1'b1; mreq.node = 32'(sa_q); mreq.w = sfh_pkg::W_SIZE;
			end
			S_U1: begin
				mreq.rd = (mrd >= sfh_pkg::FREE_HDR); mreq.node = 32'(sa_q);
				mreq.w = sfh_pkg::W_NEXT;
			end
			S_U2: begin
				mreq.rd = 1'b1; mreq.node = 32'(sa_q); mreq.w = sfh_pkg::W_PREV;
			end
			S_U3: begin
				mreq.wr = 1'b1; mreq.node = t1_q; mreq.w = sfh_pkg::W_PREV; mreq.wdata = mrd;
			end
			S_U4: begin
				mreq.wr = 1'b1; mreq.node = t2_q; mreq.w = sfh_pkg::W_NEXT; mreq.wdata = t1_q;
			end
			S_L0: begin
				mreq.rd = 1'b1; mreq.node = lbin_node; mreq.w = sfh_pkg::W_NEXT;
			end
			S_L1: begin
				mreq.rd = 1'b1; mreq.node = mrd; mreq.w = sfh_pkg::W_PREV;
			end
			S_L2: begin
				mreq.wr = 1'b1; mreq.node = mrd; mreq.w = sfh_pkg::W_NEXT;
				mreq.wdata = 32'(sa_q);
			end
			S_L3: begin
				mreq.wr = 1'b1; mreq.node = 32'(sa_q); mreq.w = sfh_pkg::W_PREV;
				mreq.wdata = t2_q;
			end
			S_L4: begin
				mreq.wr = 1'b1; mreq.node = 32'(sa_q); mreq.w = sfh_pkg::W_NEXT;
				mreq.wdata = t1_q;
			end
			S_L5: begin
				mreq.wr = 1'b1; mreq.node = t1_q; mreq.w = sfh_pkg::W_PREV;
				mreq.wdata = 32'(sa_q);
			end
			S_P1: begin
				mreq.wr = 1'b1; mreq.node = 32'(sa_q); mreq.w = sfh_pkg::W_SIZE;
				mreq.wdata = mrd | sfh_pkg::F_PREV_EMPTY;
			end
			S_P2: begin
				mreq.wr = 1'b1; mreq.node = 32'(sa_q); mreq.w = sfh_pkg::W_PSIZE;
				mreq.wdata = sv_q;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			ret_q      <= S_IDLE;
			rsize_q    <= '0;
			bin_q      <= '0;
			addr_q     <= '0;
			nxt_q      <= '0;
			prev_q     <= '0;
			sa_q       <= '0;
			sv_q       <= '0;
			sw_q       <= '0;
			size_q     <= '0;
			nsize_q    <= '0;
			nempty_q   <= 1'b0;
			psize_q    <= '0;
			user_q     <= '0;
			newb_q     <= '0;
			split_q    <= 1'b0;
			t1_q       <= '0;
			t2_q       <= '0;
			status_q   <= 1'b0;
			out_vld_q  <= 1'b0;
			out_user_q <= '0;
			out_stat_q <= 1'b0;
		end else begin
			if (out_vld_q && rsp.ready && state_q != S_DONE) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					if (mem_ready) begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					sa_q    <= BODY_START[HEAP_BITS-1:0];
					sv_q    <= BSIZE;
					ret_q   <= S_INIT2;
					state_q <= S_L0;
				end
				S_INIT2: begin
					sa_q    <= HEAP_BITS'(BODY_START + BSIZE);
					sv_q    <= BSIZE;
					ret_q   <= S_IDLE;
					state_q <= S_P0;
				end
				S_IDLE: begin
					user_q   <= '0;
					status_q <= 1'b0;
					if (req.valid) begin
						rsize_q <= req.req_size;
						addr_q  <= HEAP_BITS'(32'(req.free_offset) - sfh_pkg::USED_HDR);
						if (!req.req_type) begin
							state_q <= S_A0;
						end else if (req.free_offset == 16'd0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_F0;
						end
					end
				end
				S_A0: begin
					bin_q <= BW'(sfh_pkg::class_of(32'(rsize_q), HEAP_BITS) + 32'd1);
					if (sfh_pkg::class_of(32'(rsize_q), HEAP_BITS) + 32'd1 >= 32'(NBINS)) begin
						status_q <= 1'b1;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_A1;
					end
				end
				S_A1: begin
					state_q <= S_A2;
				end
				S_A2: begin
					if (mrd == bin_node) begin
						bin_q <= bin_q + BW'(1);
						if (32'(bin_q) + 32'd1 >= 32'(NBINS)) begin
							status_q <= 1'b1;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_A1;
						end
					end else begin
						addr_q  <= mrd[HEAP_BITS-1:0];
						state_q <= S_A3;
					end
				end
				S_A3: begin
					state_q <= S_A4;
				end
				S_A4: begin
					nxt_q   <= nxt_w;
					user_q  <= user_w;
					newb_q  <= newb_w;
					split_q <= newb_w >= 32'(addr_q) + sfh_pkg::FREE_HDR;
					sa_q    <= addr_q;
					ret_q   <= S_A5;
					state_q <= S_U0;
				end
				S_A5: begin
					if (split_q) begin
						size_q  <= newb_q - 32'(addr_q);
						sv_q    <= newb_q - 32'(addr_q);
						sa_q    <= addr_q;
						ret_q   <= S_A6;
						state_q <= S_L0;
					end else begin
						state_q <= S_W0;
					end
				end
				S_A6: begin
					sa_q    <= newb_q[HEAP_BITS-1:0];
					sv_q    <= size_q;
					ret_q   <= S_A7;
					state_q <= S_P0;
				end
				S_A7: begin
					state_q <= S_A8;
				end
				S_A8: begin
					state_q <= S_DONE;
				end
				S_W0: begin
					state_q <= S_W1;
				end
				S_W1: begin
					user_q  <= 32'(addr_q) + sfh_pkg::USED_HDR;
					state_q <= S_A7;
				end
				S_F0: begin
					state_q <= S_F1;
				end
				S_F1: begin
					sw_q    <= mrd;
					size_q  <= csz;
					nxt_q   <= nxt_w;
					state_q <= S_F2;
				end
				S_F2: begin
					state_q <= S_F3;
				end
				S_F3: begin
					nsize_q  <= csz;
					nempty_q <= mrd[0];
					if (sw_q[1]) begin
						state_q <= S_F4;
					end else if (mrd[0]) begin
						state_q <= S_B0;
					end else begin
						state_q <= S_C0;
					end
				end
				S_F4: begin
					psize_q <= mrd;
					prev_q  <= addr_q - mrd[HEAP_BITS-1:0];
					sa_q    <= addr_q - mrd[HEAP_BITS-1:0];
					ret_q   <= S_F5;
					state_q <= S_U0;
				end
				S_F5: begin
					if (nempty_q) begin
						sa_q    <= nxt_q;
						ret_q   <= S_F6;
						state_q <= S_U0;
					end else begin
						psize_q <= psize_q + size_q;
						state_q <= S_F7;
					end
				end
				S_F6: begin
					psize_q <= psize_q + size_q + nsize_q;
					state_q <= S_F7;
				end
				S_F7: begin
					sa_q    <= prev_q;
					sv_q    <= psize_q;
					ret_q   <= S_F8;
					state_q <= S_L0;
				end
				S_F8: begin
					sa_q    <= nempty_q ? (prev_q + psize_q[HEAP_BITS-1:0]) : nxt_q;
					sv_q    <= psize_q;
					ret_q   <= S_DONE;
					state_q <= S_P0;
				end
				S_B0: begin
					sa_q    <= nxt_q;
					ret_q   <= S_B1;
					state_q <= S_U0;
				end
				S_B1: begin
					size_q  <= size_q + nsize_q;
					state_q <= S_B2;
				end
				S_B2: begin
					sa_q    <= addr_q;
					sv_q    <= size_q;
					ret_q   <= S_B3;
					state_q <= S_L0;
				end
				S_B3: begin
					state_q <= S_DONE;
				end
				S_C0: begin
					if (size_q >= sfh_pkg::FREE_HDR) begin
						sa_q    <= addr_q;
						sv_q    <= size_q;
						ret_q   <= S_C1;
						state_q <= S_L0;
					end else begin
						state_q <= S_C1;
					end
				end
				S_C1: begin
					state_q <= S_C2;
				end
				S_C2: begin
					sa_q    <= nxt_q;
					sv_q    <= size_q;
					ret_q   <= S_DONE;
					state_q <= S_P0;
				end
				S_U0: begin
					state_q <= S_U1;
				end
				S_U1: begin
					state_q <= (mrd >= sfh_pkg::FREE_HDR) ? S_U2 : ret_q;
				end
				S_U2: begin
					t1_q    <= mrd;
					state_q <= S_U3;
				end
				S_U3: begin
					t2_q    <= mrd;
					state_q <= S_U4;
				end
				S_U4: begin
					state_q <= ret_q;
				end
				S_L0: begin
					state_q <= S_L1;
				end
				S_L1: begin
					t1_q    <= mrd;
					state_q <= S_L2;
				end
				S_L2: begin
					t2_q    <= mrd;
					state_q <= S_L3;
				end
				S_L3: begin
					state_q <= S_L4;
				end
				S_L4: begin
					state_q <= S_L5;
				end
				S_L5: begin
					state_q <= ret_q;
				end
				S_P0: begin
					state_q <= S_P1;
				end
				S_P1: begin
					state_q <= S_P2;
				end
				S_P2: begin
					state_q <= ret_q;
				end
				S_DONE: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q  <= 1'b1;
						out_user_q <= 16'(user_q & HEAP_MASK);
						out_stat_q <= status_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_vld_q;
	assign rsp.user_offset = out_user_q;
	assign rsp.status      = out_stat_q;

endmodule

// ===== hdl/sfh_store.sv =====
// ----------------------------------------------------------------------------
// sfh_store
// Heap word memory and bin head/tail memories, one access per cycle once the
// clearing pass after reset is done, registered read data.
// ----------------------------------------------------------------------------
module sfh_store #(
	parameter int HEAP_BITS = sfh_pkg::HEAP_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sfh_pkg::sfh_mreq_t mreq,
	output logic [31:0]       rdata,
	output logic              ready
);
	localparam int WB    = HEAP_BITS - 2;
	localparam int WORDS = 1 << WB;
	localparam int NBINS = (HEAP_BITS - 3) * 4;
	localparam int BB    = $clog2(NBINS);
	localparam logic [31:0] HEAP_SIZE = 32'(1) << HEAP_BITS;

	logic [31:0] heap_q [WORDS];
	logic [31:0] bfirst_q [NBINS];
	logic [31:0] blast_q [NBINS];

	logic [WB-1:0] clr_q;
	logic          done_q;
	logic [31:0]   heap_rd_q;
	logic [31:0]   bin_rd_q;
	logic          sel_q;

	logic          is_bin;
	logic [31:0]   boff;
	logic [BB-1:0] bidx;
	logic [WB-1:0] widx;

	assign boff   = mreq.node - HEAP_SIZE;
	assign is_bin = (mreq.node >= HEAP_SIZE) && (boff < 32'(NBINS));
	assign bidx   = is_bin ? boff[BB-1:0] : '0;
	assign widx   = mreq.node[HEAP_BITS-1:2] + WB'(mreq.w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
		end else if (!done_q) begin
			clr_q <= clr_q + WB'(1);
			if (clr_q == WB'(WORDS - 1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!done_q) begin
			heap_q[clr_q] <= '0;
			if (32'(clr_q) < 32'(NBINS)) begin
				bfirst_q[clr_q[BB-1:0]] <= HEAP_SIZE + 32'(clr_q);
				blast_q[clr_q[BB-1:0]]  <= HEAP_SIZE + 32'(clr_q);
			end
		end else if (mreq.wr) begin
			if (is_bin) begin
				if (mreq.w == sfh_pkg::W_NEXT) begin
					bfirst_q[bidx] <= mreq.wdata;
				end else begin
					blast_q[bidx] <= mreq.wdata;
				end
			end else begin
				heap_q[widx] <= mreq.wdata;
			end
		end
		heap_rd_q <= heap_q[widx];
		bin_rd_q  <= (mreq.w == sfh_pkg::W_NEXT) ? bfirst_q[bidx] : blast_q[bidx];
		sel_q     <= is_bin;
	end

	assign rdata = sel_q ? bin_rd_q : heap_rd_q;
	assign ready = done_q;

endmodule

// ===== sim/sfh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfh_checker
// Watches the request and response channels of the heap allocator. Each
// accepted request beat runs through a local copy of the heap, bins and
// boundary tags; the predicted offset and status are queued in order and
// compared field by field with each accepted response beat.
// ----------------------------------------------------------------------------
module sfh_checker (
	input  logic clk,
	input  logic arst_n,
	sfh_req_if   req,
	sfh_rsp_if   rsp,
	output int   errors,
	output int   pending
);
	localparam int          HB    = sfh_pkg::HEAP_BITS_DEF;
	localparam logic [31:0] HSIZE = 32'(1) << HB;
	localparam logic [31:0] HMASK = HSIZE - 32'd1;
	localparam int          WORDS = 1 << (HB - 2);
	localparam int          NB    = (HB - 3) * 4;
	localparam logic [31:0] AMASK = ~32'(sfh_pkg::ALIGN_BYTES_DEF - 1);

	typedef struct packed {
		logic [15:0] user_offset;
		logic        status;
	} heap_rsp_t;

	logic [31:0] heap_mem [WORDS];
	logic [31:0] bin_head [NB];
	logic [31:0] bin_tail [NB];
	heap_rsp_t   rsp_fifo [$];
	int          n_err = 0;
	int          n_pend = 0;

	assign errors  = n_err;
	assign pending = n_pend;

	function automatic int widx(input logic [31:0] a, input logic [1:0] w);
		return int'(((a >> 2) + 32'(w)) & 32'(WORDS - 1));
	endfunction

	function automatic bit in_bins(input logic [31:0] v);
		return v >= HSIZE && (v - HSIZE) < 32'(NB);
	endfunction

	function automatic logic [31:0] lnk_rd(input logic [31:0] node, input logic [1:0] w);
		if (in_bins(node))
			return (w == sfh_pkg::W_NEXT) ? bin_head[node - HSIZE] : bin_tail[node - HSIZE];
		return heap_mem[widx(node, w)];
	endfunction

	function automatic void lnk_wr(input logic [31:0] node, input logic [1:0] w,
		input logic [31:0] v);
		if (in_bins(node)) begin
			if (w == sfh_pkg::W_NEXT) bin_head[node - HSIZE] = v;
			else bin_tail[node - HSIZE] = v;
		end else begin
			heap_mem[widx(node, w)] = v;
		end
	endfunction

	function automatic logic [31:0] size_bin(input logic [31:0] s);
		logic [31:0] r;
		int          b;
		bit          found;
		found = 0;
		b = HB;
		for (int n = 1; n < HB; n++) begin
			if (!found && ((32'(1) << n) - 32'd1) >= s) begin
				b = n;
				found = 1;
			end
		end
		if (s <= 32'd32) r = s >> 2;
		else r = 32'((b - 4) * 4) + ((s >> (b - 3)) & 32'h3);
		if (r >= 32'(NB)) r = 32'(NB - 1);
		return r;
	endfunction

	function automatic void mark_prev_empty(input logic [31:0] a, input logic [31:0] ps);
		heap_mem[widx(a, sfh_pkg::W_SIZE)] =
			heap_mem[widx(a, sfh_pkg::W_SIZE)] | sfh_pkg::F_PREV_EMPTY;
		heap_mem[widx(a, sfh_pkg::W_PSIZE)] = ps;
	endfunction

	function automatic void bin_remove(input logic [31:0] a);
		logic [31:0] n, p;
		a = a & HMASK;
		if (heap_mem[widx(a, sfh_pkg::W_SIZE)] >= sfh_pkg::FREE_HDR) begin
			n = lnk_rd(a, sfh_pkg::W_NEXT);
			p = lnk_rd(a, sfh_pkg::W_PREV);
			lnk_wr(n, sfh_pkg::W_PREV, p);
			lnk_wr(p, sfh_pkg::W_NEXT, n);
		end
	endfunction

	function automatic void bin_insert(input logic [31:0] a, input logic [31:0] sz);
		logic [31:0] idx, first, last;
		idx = size_bin(sz - sfh_pkg::USED_HDR + 32'd4);
		first = bin_head[idx];
		last = lnk_rd(first, sfh_pkg::W_PREV);
		a = a & HMASK;
		lnk_wr(last, sfh_pkg::W_NEXT, a);
		lnk_wr(a, sfh_pkg::W_PREV, last);
		lnk_wr(a, sfh_pkg::W_NEXT, first);
		lnk_wr(first, sfh_pkg::W_PREV, a);
	endfunction

	function automatic bit carve(input logic [31:0] sz, output logic [31:0] uo);
		logic [31:0] cur, csz, nxt, usr, nb;
		uo = '0;
		for (int i = int'(size_bin(sz)) + 1; i < NB; i++) begin
			if (bin_head[i] == HSIZE + 32'(i)) continue;
			cur = bin_head[i] & HMASK;
			csz = heap_mem[widx(cur, sfh_pkg::W_SIZE)] & sfh_pkg::SIZE_FIELD;
			nxt = (cur + csz) & HMASK;
			usr = (nxt + 32'd4 - sz) & AMASK;
			nb = usr - sfh_pkg::USED_HDR;
			if (nb >= cur + sfh_pkg::FREE_HDR) begin
				bin_remove(cur);
				csz = nb - cur;
				heap_mem[widx(cur, sfh_pkg::W_SIZE)] = csz | sfh_pkg::F_EMPTY;
				bin_insert(cur, csz);
				heap_mem[widx(nb, sfh_pkg::W_SIZE)] = nxt - nb;
				mark_prev_empty(nb, csz);
			end else begin
				bin_remove(cur);
				heap_mem[widx(cur, sfh_pkg::W_SIZE)] =
					heap_mem[widx(cur, sfh_pkg::W_SIZE)] & ~sfh_pkg::F_EMPTY;
				usr = cur + sfh_pkg::USED_HDR;
			end
			heap_mem[widx(nxt, sfh_pkg::W_SIZE)] =
				heap_mem[widx(nxt, sfh_pkg::W_SIZE)] & ~sfh_pkg::F_PREV_EMPTY;
			uo = usr & HMASK;
			return 1;
		end
		return 0;
	endfunction

	function automatic void release_blk(input logic [31:0] p);
		logic [31:0] addr, sw, sz, nxt, nsw, nsz, ps, prv;
		bit          nxt_empty;
		addr = (p - sfh_pkg::USED_HDR) & HMASK;
		sw = heap_mem[widx(addr, sfh_pkg::W_SIZE)];
		sz = sw & sfh_pkg::SIZE_FIELD;
		nxt = (addr + sz) & HMASK;
		nsw = heap_mem[widx(nxt, sfh_pkg::W_SIZE)];
		nsz = nsw & sfh_pkg::SIZE_FIELD;
		nxt_empty = (nsw & sfh_pkg::F_EMPTY) != 0;
		if ((sw & sfh_pkg::F_PREV_EMPTY) != 0) begin
			ps = heap_mem[widx(addr, sfh_pkg::W_PSIZE)];
			prv = (addr - ps) & HMASK;
			bin_remove(prv);
			if (nxt_empty) begin
				bin_remove(nxt);
				ps = ps + sz + nsz;
				heap_mem[widx(prv, sfh_pkg::W_SIZE)] = ps | sfh_pkg::F_EMPTY;
				bin_insert(prv, ps);
				mark_prev_empty(prv + ps, ps);
			end else begin
				ps = ps + sz;
				heap_mem[widx(prv, sfh_pkg::W_SIZE)] = ps | sfh_pkg::F_EMPTY;
				bin_insert(prv, ps);
				mark_prev_empty(nxt, ps);
			end
		end else if (nxt_empty) begin
			bin_remove(nxt);
			sz = sz + nsz;
			heap_mem[widx(addr, sfh_pkg::W_SIZE)] = sz | sfh_pkg::F_EMPTY;
			bin_insert(addr, sz);
			heap_mem[widx(addr + sz, sfh_pkg::W_PSIZE)] = sz;
		end else begin
			if (sz >= sfh_pkg::FREE_HDR) bin_insert(addr, sz);
			heap_mem[widx(addr, sfh_pkg::W_SIZE)] =
				heap_mem[widx(addr, sfh_pkg::W_SIZE)] | sfh_pkg::F_EMPTY;
			mark_prev_empty(nxt, sz);
		end
	endfunction

	function automatic void heap_init();
		logic [31:0] body, bsz;
		body = 32'((sfh_pkg::ALIGN_BYTES_DEF - (8 % sfh_pkg::ALIGN_BYTES_DEF))
			% sfh_pkg::ALIGN_BYTES_DEF);
		bsz = HSIZE - body - 32'd8;
		for (int i = 0; i < WORDS; i++) heap_mem[i] = '0;
		for (int i = 0; i < NB; i++) begin
			bin_head[i] = HSIZE + 32'(i);
			bin_tail[i] = HSIZE + 32'(i);
		end
		bin_insert(body, bsz);
		heap_mem[widx(body, sfh_pkg::W_SIZE)] = bsz | sfh_pkg::F_EMPTY;
		mark_prev_empty(body + bsz, bsz);
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		n_err++;
		$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
	endtask

	initial begin
		heap_init();
	end

	always @(posedge clk) begin
		heap_rsp_t   e;
		logic [31:0] uo;
		if (arst_n && req.valid && req.ready) begin
			e = '0;
			if (req.req_type == 1'b0) begin
				if (carve(32'(req.req_size), uo)) e.user_offset = uo[15:0];
				else e.status = 1'b1;
			end else if (req.free_offset != '0) begin
				release_blk(32'(req.free_offset));
			end
			rsp_fifo.push_back(e);
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (rsp_fifo.size() == 0) begin
				report("unexpected beat", 32'(rsp.user_offset), '0);
			end else begin
				e = rsp_fifo.pop_front();
				if (rsp.user_offset !== e.user_offset)
					report("user_offset", 32'(rsp.user_offset), 32'(e.user_offset));
				if (rsp.status !== e.status)
					report("status", 32'(rsp.status), 32'(e.status));
			end
		end
		n_pend = rsp_fifo.size();
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives allocate and free requests into the heap allocator with random
// gaps and response stalls, including a long response hold-off, and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;
	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   n_alloc, n_free;
	int   n_nospace = 0;
	bit   hold_req;
	bit   burst_mode;
	logic [15:0] live [$];

	sfh_req_if req ();
	sfh_rsp_if rsp ();

	segregated_fit_heap_allocator i_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	sfh_checker i_chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.errors(errors), .pending(pending));

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	initial begin
		#10ms;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int draw_gap();
		return burst_mode ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic send(input logic t, input logic [15:0] sz, input logic [15:0] off);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.req_type <= t;
		req.req_size <= sz;
		req.free_offset <= off;
		req.valid <= 1'b1;
		if (t) n_free++;
		else n_alloc++;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic alloc(input logic [15:0] sz);
		send(1'b0, sz, 16'($urandom));
	endtask

	task automatic free_live();
		int k;
		logic [15:0] o;
		if (live.size() == 0) begin
			send(1'b1, 16'($urandom), 16'd0);
		end else begin
			k = $urandom_range(0, live.size() - 1);
			o = live[k];
			live.delete(k);
			send(1'b1, 16'($urandom), o);
		end
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// response side: random stall per beat, one long hold-off on request
	initial begin
		int gap;
		bit held;
		held = 0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1;
				gap = 400;
			end else begin
				gap = draw_gap();
			end
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
			if (rsp.status == 1'b0 && rsp.user_offset != '0)
				live.push_back(rsp.user_offset);
			if (rsp.status) n_nospace++;
		end
	end

	initial begin
		int r;
		logic [15:0] o;
		n_alloc = 0;
		n_free = 0;
		hold_req = 0;
		burst_mode = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = 1'b0;
		req.req_size = '0;
		req.free_offset = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed: size extremes, class edges, no space, null free, small blocks
		alloc(16'd0);
		alloc(16'd1);
		alloc(16'd4);
		alloc(16'd8);
		alloc(16'd31);
		alloc(16'd32);
		alloc(16'd33);
		alloc(16'd100);
		alloc(16'hFFFF);
		alloc(16'h8000);
		alloc(16'd40000);
		send(1'b1, 16'hFFFF, 16'd0);
		alloc(16'd2);
		alloc(16'd3);
		drain();
		repeat (8) free_live();
		alloc(16'd12);
		alloc(16'd20000);
		alloc(16'd30000);
		alloc(16'd16000);
		drain();
		repeat (6) free_live();
		drain();

		// random: mostly well-formed alloc/free traffic
		for (int i = 0; i < 520; i++) begin
			if (i == 200) begin
				hold_req = 1;
				burst_mode = 1;
			end
			if (i == 240) burst_mode = 0;
			if (i % 100 == 60) burst_mode = ~burst_mode;
			r = $urandom_range(0, 99);
			if (r < 45) alloc(16'($urandom_range(0, 64)));
			else if (r < 55) alloc(16'($urandom_range(65, 1024)));
			else if (r < 58) alloc(16'($urandom_range(1025, 16384)));
			else if (r < 59) alloc(16'($urandom));
			else if (r < 97) free_live();
			else send(1'b1, 16'($urandom), 16'd0);
			if (live.size() == 0 && r >= 59) drain();
		end
		drain();

		// broken frees last: double free and stray offsets
		if (live.size() != 0) begin
			o = live[0];
			send(1'b1, 16'd0, o);
			send(1'b1, 16'hFFFF, o);
		end
		for (int i = 0; i < 12; i++) send(1'b1, 16'($urandom), 16'($urandom));
		send(1'b1, 16'h0000, 16'hFFFF);
		alloc(16'($urandom_range(0, 200)));
		alloc(16'($urandom_range(0, 200)));
		drain();

		$display("Covered %0d allocates (%0d without space) and %0d frees,",
			n_alloc, n_nospace, n_free);
		$display("with random gaps, stalls, one long response hold-off and stray frees.");
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/sfh_pkg.sv
hdl/sfh_if.sv
hdl/sfh_store.sv
hdl/segregated_fit_heap_allocator.sv
sim/sfh_checker.sv
sim/tb.sv
